// ===== rtl/bounded_array_stack_search_sort_unit_assert.svh =====
// Assertion macros shared by the bounded array stack unit.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BOUNDED_ARRAY_STACK_SEARCH_SORT_UNIT_ASSERT_SVH
`define BOUNDED_ARRAY_STACK_SEARCH_SORT_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BASSU_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define BASSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define BASSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bassu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bassu_pkg;

    // Width of one stored element.
    localparam int unsigned ELEM_W = 32;

    // Operation codes carried by an input transaction.
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_SORT   = 3'd3,
        OP_LIST   = 3'd4
    } t_op;

    // Status codes carried by a result transaction.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Source of the next value held by one cell of the chain.
    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_NEXT,
        SEL_PREV,
        SEL_HEAD
    } t_cell_sel;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SORT   = 4'b0100,
        S_LIST   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/bounded_array_stack_search_sort_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_operation, i_value
// result    out        o_valid / i_stall  o_status, o_element, o_index, o_last
//
// Insert and delete each give a single result.
// Search rotates the chain of cells once through and gives one result.
// Sort runs fill_count rounds of odd-even transposition, then lists like list does:
// fill_count results, one per cycle while the result side does not stall.
// Reset clears the fill count and the sequencer; cell contents are left as they are.
// A stall on the result side freezes rotation; the input is taken only when idle.

`include "bounded_array_stack_search_sort_unit_assert.svh"

module bounded_array_stack_search_sort_unit #(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [2:0]                          i_operation,
    input  wire logic signed [bassu_pkg::ELEM_W-1:0] i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [1:0]                               o_status,
    output logic signed [bassu_pkg::ELEM_W-1:0]      o_element,
    output logic [2:0]                               o_index,
    output logic                                     o_last
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    bassu_pkg::t_state                   r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [IW-1:0]                       r_step, n_step;
    logic signed [bassu_pkg::ELEM_W-1:0] r_val, n_val;
    logic                                r_found, n_found;
    logic [IW-1:0]                       r_at, n_at;

    logic                                r_out_valid, n_out_valid;
    bassu_pkg::t_status                  r_out_status, n_out_status;
    logic signed [bassu_pkg::ELEM_W-1:0] r_out_element, n_out_element;
    logic [2:0]                          r_out_index, n_out_index;
    logic                                r_out_last, n_out_last;

    logic signed [bassu_pkg::ELEM_W-1:0] w_val [DEPTH];
    logic [DEPTH-1:0]                    w_gt;
    bassu_pkg::t_cell_sel                w_sel [DEPTH];

    logic              w_out_free;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic [CW-1:0]     w_last_pos;
    logic              w_step_end;
    logic              w_match;
    logic              w_load;
    logic              w_rotate;
    logic              w_sort;
    bassu_pkg::t_op    w_op;

    // Handshake and fill status.
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == bassu_pkg::S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = r_count == CW'(DEPTH);
    assign w_empty    = r_count == '0;
    assign w_last_pos = r_count - 1'b1;
    assign w_step_end = CW'(r_step) == w_last_pos;
    assign w_match    = w_val[0] == r_val;
    assign w_op       = bassu_pkg::t_op'(i_operation);

    // Sequencer: decides the chain action and the result of each cycle.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_val         = r_val;
        n_found       = r_found;
        n_at          = r_at;
        n_out_valid   = r_out_valid && i_stall;
        n_out_status  = r_out_status;
        n_out_element = r_out_element;
        n_out_index   = r_out_index;
        n_out_last    = r_out_last;
        w_load        = 1'b0;
        w_rotate      = 1'b0;
        w_sort        = 1'b0;

        case (r_state)
            bassu_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_element = '0;
                    n_out_index   = '0;
                    n_out_last    = 1'b1;
                    n_out_status  = bassu_pkg::ST_OK;
                    n_step        = '0;
                    case (w_op)
                        bassu_pkg::OP_INSERT: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_status = bassu_pkg::ST_FULL;
                            end else begin
                                w_load  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        bassu_pkg::OP_DELETE: begin
                            n_out_valid = 1'b1;
                            if (w_empty) begin
                                n_out_status = bassu_pkg::ST_EMPTY;
                            end else begin
                                n_count       = w_last_pos;
                                n_out_element = w_val[w_last_pos[IW-1:0]];
                                n_out_index   = 3'(w_last_pos);
                            end
                        end
                        bassu_pkg::OP_SEARCH: begin
                            if (w_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = bassu_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = bassu_pkg::S_SEARCH;
                                n_val   = i_value;
                                n_found = 1'b0;
                                n_at    = '0;
                            end
                        end
                        bassu_pkg::OP_SORT: begin
                            if (w_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = bassu_pkg::ST_EMPTY;
                            end else begin
                                n_state = bassu_pkg::S_SORT;
                            end
                        end
                        bassu_pkg::OP_LIST: begin
                            if (w_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = bassu_pkg::ST_EMPTY;
                            end else begin
                                n_state = bassu_pkg::S_LIST;
                            end
                        end
                        default: begin
                            // Unused codes are dropped without a result.
                        end
                    endcase
                end
            end
            bassu_pkg::S_SEARCH: begin
                if (w_out_free) begin
                    w_rotate = 1'b1;
                    n_step   = IW'(r_step + 1'b1);
                    if (w_match) begin
                        n_found = 1'b1;
                        n_at    = r_step;
                    end
                    if (w_step_end) begin
                        n_state       = bassu_pkg::S_IDLE;
                        n_out_valid   = 1'b1;
                        n_out_element = '0;
                        n_out_last    = 1'b1;
                        if (w_match) begin
                            n_out_status = bassu_pkg::ST_OK;
                            n_out_index  = 3'(r_step);
                        end else if (r_found) begin
                            n_out_status = bassu_pkg::ST_OK;
                            n_out_index  = 3'(r_at);
                        end else begin
                            n_out_status = bassu_pkg::ST_NOT_FOUND;
                            n_out_index  = '0;
                        end
                    end
                end
            end
            bassu_pkg::S_SORT: begin
                w_sort = 1'b1;
                n_step = IW'(r_step + 1'b1);
                if (w_step_end) begin
                    n_state = bassu_pkg::S_LIST;
                    n_step  = '0;
                end
            end
            bassu_pkg::S_LIST: begin
                if (w_out_free) begin
                    w_rotate      = 1'b1;
                    n_step        = IW'(r_step + 1'b1);
                    n_out_valid   = 1'b1;
                    n_out_status  = bassu_pkg::ST_OK;
                    n_out_element = w_val[0];
                    n_out_index   = 3'(r_step);
                    n_out_last    = w_step_end;
                    if (w_step_end) begin
                        n_state = bassu_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bassu_pkg::S_IDLE;
            end
        endcase
    end

    // The chain of cells, each choosing its source from its position.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [bassu_pkg::ELEM_W-1:0] w_next;
        logic signed [bassu_pkg::ELEM_W-1:0] w_prev;
        logic                                w_prev_swap;

        if (i < DEPTH - 1) begin : g_next
            assign w_next = w_val[i+1];
        end else begin : g_wrap
            assign w_next = w_val[0];
        end

        if (i > 0) begin : g_prev
            assign w_prev      = w_val[i-1];
            assign w_prev_swap = (1'((i - 1) % 2) == r_step[0]) && (CW'(i) < r_count)
                                 && w_gt[i-1];
        end else begin : g_first
            assign w_prev      = w_val[0];
            assign w_prev_swap = 1'b0;
        end

        always_comb begin
            w_sel[i] = bassu_pkg::SEL_HOLD;
            if (w_load) begin
                if (r_count == CW'(i)) begin
                    w_sel[i] = bassu_pkg::SEL_LOAD;
                end
            end else if (w_rotate) begin
                if (CW'(i) < w_last_pos) begin
                    w_sel[i] = bassu_pkg::SEL_NEXT;
                end else if (CW'(i) == w_last_pos) begin
                    w_sel[i] = bassu_pkg::SEL_HEAD;
                end
            end else if (w_sort) begin
                if ((1'(i % 2) == r_step[0]) && (CW'(i + 1) < r_count) && w_gt[i]) begin
                    w_sel[i] = bassu_pkg::SEL_NEXT;
                end else if (w_prev_swap) begin
                    w_sel[i] = bassu_pkg::SEL_PREV;
                end
            end
        end

        bassu_cell u_cell (
            .i_clk     (i_clk),
            .i_sel     (w_sel[i]),
            .i_load    (i_value),
            .i_next    (w_next),
            .i_prev    (w_prev),
            .i_head    (w_val[0]),
            .o_value   (w_val[i]),
            .o_gt_next (w_gt[i])
        );
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bassu_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_step        <= n_step;
        r_val         <= n_val;
        r_found       <= n_found;
        r_at          <= n_at;
        r_out_status  <= n_out_status;
        r_out_element <= n_out_element;
        r_out_index   <= n_out_index;
        r_out_last    <= n_out_last;
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_element = r_out_element;
    assign o_index   = r_out_index;
    assign o_last    = r_out_last;

    // The fill count never passes the depth.
    `BASSU_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "fill count beyond depth")
    // A busy sequencer always has elements to work on.
    `BASSU_ASSERT_IMPL(a_busy_nonempty, r_state != bassu_pkg::S_IDLE, r_count != '0,
                       "busy with an empty array")
    // An insert into a non-full array grows the count by one.
    `BASSU_ASSERT_NEXT(a_insert_grow, w_accept && (w_op == bassu_pkg::OP_INSERT) && !w_full,
                       r_count == CW'($past(r_count) + 1'b1), "insert did not grow count")
    // Input is taken only while the sequencer is idle.
    `BASSU_ASSERT_IMPL(a_accept_idle, w_accept, r_state == bassu_pkg::S_IDLE,
                       "input taken while busy")

endmodule

`default_nettype wire

// ===== rtl/bassu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bassu_cell (
    input  wire logic                                i_clk,
    input  wire bassu_pkg::t_cell_sel                i_sel,
    input  wire logic signed [bassu_pkg::ELEM_W-1:0] i_load,
    input  wire logic signed [bassu_pkg::ELEM_W-1:0] i_next,
    input  wire logic signed [bassu_pkg::ELEM_W-1:0] i_prev,
    input  wire logic signed [bassu_pkg::ELEM_W-1:0] i_head,
    output logic signed [bassu_pkg::ELEM_W-1:0]      o_value,
    output logic                                     o_gt_next
);

    logic signed [bassu_pkg::ELEM_W-1:0] r_value;
    logic signed [bassu_pkg::ELEM_W-1:0] n_value;

    // Pick the next value from a neighbour, the head or the load bus, or hold it.
    always_comb begin
        case (i_sel)
            bassu_pkg::SEL_LOAD: n_value = i_load;
            bassu_pkg::SEL_NEXT: n_value = i_next;
            bassu_pkg::SEL_PREV: n_value = i_prev;
            bassu_pkg::SEL_HEAD: n_value = i_head;
            default:             n_value = r_value;
        endcase
    end

    // The element itself needs no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Compare with the right-hand neighbour for the transposition sort.
    assign o_gt_next = r_value > i_next;
    assign o_value   = r_value;

endmodule

`default_nettype wire
